### rtl/pwrp_pkg.sv
// ----------------------------------------------------------------------------
// pwrp_pkg
// Shared types, constants and the protocol string table for the peer-wire
// receive parser.
// ----------------------------------------------------------------------------
package pwrp_pkg;

    localparam int unsigned CNT_W       = 25;
    localparam int unsigned HIDX_W      = 5;
    localparam int unsigned ADDR_W      = 3;
    localparam int unsigned QDEPTH      = 4;
    localparam int unsigned QPTR_W      = $clog2(QDEPTH);

    localparam logic [CNT_W-1:0]  HS_PROTO_LEN  = 25'd20;
    localparam logic [CNT_W-1:0]  HS_HASH_START = 25'd28;
    localparam logic [CNT_W-1:0]  HS_LAST       = 25'd47;
    localparam logic [CNT_W-1:0]  PEER_ID_LAST  = 25'd19;
    localparam logic [CNT_W-1:0]  LEN_LAST      = 25'd3;
    localparam logic [CNT_W-1:0]  PAYLOAD_HEAD  = 25'd8;
    localparam logic [CNT_W-1:0]  REQ_MSG_LEN   = 25'd13;
    localparam logic [CNT_W-1:0]  MAX_LEN_RESET = 25'd262144;
    localparam logic [HIDX_W-1:0] HASH_LAST     = 5'd19;

    localparam logic [7:0] TYPE_REQUEST = 8'd6;
    localparam logic [7:0] TYPE_CANCEL  = 8'd8;

    // register map
    localparam logic [ADDR_W-1:0] ADDR_MAX_LEN = 3'd0;

    typedef enum logic [2:0] {
        PH_HANDSHAKE,
        PH_PEERID,
        PH_LENGTH,
        PH_MESSAGE,
        PH_HALTED
    } t_phase;

    typedef enum logic [2:0] {
        EV_HASH      = 3'd0,
        EV_BADPROTO  = 3'd1,
        EV_KEEPALIVE = 3'd2,
        EV_REQUEST   = 3'd3,
        EV_CANCEL    = 3'd4,
        EV_IGNORED   = 3'd5,
        EV_TOOLONG   = 3'd6
    } t_event;

    // command from front to back; a hash command expands into 20 items
    typedef struct packed {
        t_event      ev;
        logic [7:0]  msg_type;
        logic [31:0] piece;
        logic [31:0] offset;
        logic [31:0] length;
    } t_cmd;

    // hash store write from the front
    typedef struct packed {
        logic              en;
        logic [HIDX_W-1:0] idx;
        logic [7:0]        data;
    } t_hash_wr;

    // expected protocol string: length byte then "BitTorrent protocol"
    function automatic logic [7:0] proto_byte(input logic [HIDX_W-1:0] idx);
        logic [7:0] b;
        case (idx)
            5'd0:    b = 8'd19;
            5'd1:    b = "B";
            5'd2:    b = "i";
            5'd3:    b = "t";
            5'd4:    b = "T";
            5'd5:    b = "o";
            5'd6:    b = "r";
            5'd7:    b = "r";
            5'd8:    b = "e";
            5'd9:    b = "n";
            5'd10:   b = "t";
            5'd11:   b = " ";
            5'd12:   b = "p";
            5'd13:   b = "r";
            5'd14:   b = "o";
            5'd15:   b = "t";
            5'd16:   b = "o";
            5'd17:   b = "c";
            5'd18:   b = "o";
            5'd19:   b = "l";
            default: b = 8'd0;
        endcase
        return b;
    endfunction

endpackage

### rtl/pwrp_front.sv
// ----------------------------------------------------------------------------
// pwrp_front
// Byte parser: tracks the handshake and message framing, holds the length
// limit register and turns finished units into commands for the back end.
// ----------------------------------------------------------------------------
module pwrp_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // byte input
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [7:0]                    i_rx_byte,
    // configuration write
    input  logic                          i_cfg_we,
    input  logic [pwrp_pkg::ADDR_W-1:0]   i_cfg_addr,
    input  logic [31:0]                   i_cfg_wdata,
    output logic [pwrp_pkg::CNT_W-1:0]    o_max_len,
    // command queue
    input  logic                          i_q_full,
    output logic                          o_push,
    output pwrp_pkg::t_cmd                o_cmd,
    // hash store write
    output pwrp_pkg::t_hash_wr            o_hash_wr
);
    import pwrp_pkg::*;

    t_phase            r_phase, n_phase;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_mismatch, n_mismatch;
    logic [31:0]       r_len_shift, n_len_shift;
    logic [CNT_W-1:0]  r_msg_len, n_msg_len;
    logic [7:0]        r_type, n_type;
    logic [63:0]       r_pay_shift, n_pay_shift;
    logic [31:0]       r_pay_tail, n_pay_tail;
    logic [CNT_W-1:0]  r_max_len;
    logic              accept;
    logic [CNT_W-1:0]  count_inc;

    assign o_ready   = !i_q_full;
    assign accept    = i_valid && !i_q_full;
    assign count_inc = r_count + 1'b1;
    assign o_max_len = r_max_len;

    // length limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_LEN_RESET;
        end else if (i_cfg_we && i_cfg_addr == ADDR_MAX_LEN) begin
            r_max_len <= i_cfg_wdata[CNT_W-1:0];
        end
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HANDSHAKE;
            r_count     <= '0;
            r_mismatch  <= 1'b0;
            r_len_shift <= '0;
            r_msg_len   <= '0;
            r_type      <= '0;
            r_pay_shift <= '0;
            r_pay_tail  <= '0;
        end else begin
            r_phase     <= n_phase;
            r_count     <= n_count;
            r_mismatch  <= n_mismatch;
            r_len_shift <= n_len_shift;
            r_msg_len   <= n_msg_len;
            r_type      <= n_type;
            r_pay_shift <= n_pay_shift;
            r_pay_tail  <= n_pay_tail;
        end
    end

    // next state and command generation
    always_comb begin
        n_phase     = r_phase;
        n_count     = r_count;
        n_mismatch  = r_mismatch;
        n_len_shift = r_len_shift;
        n_msg_len   = r_msg_len;
        n_type      = r_type;
        n_pay_shift = r_pay_shift;
        n_pay_tail  = r_pay_tail;
        o_push      = 1'b0;
        o_cmd       = '0;
        o_hash_wr   = '0;

        if (accept) begin
            unique case (r_phase)
                PH_HANDSHAKE: begin
                    if (r_count < HS_PROTO_LEN) begin
                        if (i_rx_byte != proto_byte(r_count[HIDX_W-1:0])) begin
                            n_mismatch = 1'b1;
                        end
                    end else if (r_count >= HS_HASH_START) begin
                        o_hash_wr.en   = 1'b1;
                        o_hash_wr.idx  = HIDX_W'(r_count - HS_HASH_START);
                        o_hash_wr.data = i_rx_byte;
                    end
                    n_count = count_inc;
                    if (r_count == HS_LAST) begin
                        n_count = '0;
                        o_push  = 1'b1;
                        if (n_mismatch) begin
                            n_phase  = PH_HALTED;
                            o_cmd.ev = EV_BADPROTO;
                        end else begin
                            n_phase  = PH_PEERID;
                            o_cmd.ev = EV_HASH;
                        end
                    end
                end
                PH_PEERID: begin
                    n_count = count_inc;
                    if (r_count == PEER_ID_LAST) begin
                        n_count     = '0;
                        n_len_shift = '0;
                        n_phase     = PH_LENGTH;
                    end
                end
                PH_LENGTH: begin
                    n_len_shift = {r_len_shift[23:0], i_rx_byte};
                    n_count     = count_inc;
                    if (r_count == LEN_LAST) begin
                        n_count = '0;
                        if (n_len_shift == '0) begin
                            o_push   = 1'b1;
                            o_cmd.ev = EV_KEEPALIVE;
                        end else if (n_len_shift > {7'd0, r_max_len}) begin
                            o_push   = 1'b1;
                            o_cmd.ev = EV_TOOLONG;
                            n_phase  = PH_HALTED;
                        end else begin
                            n_msg_len   = n_len_shift[CNT_W-1:0];
                            n_type      = '0;
                            n_pay_shift = '0;
                            n_pay_tail  = '0;
                            n_phase     = PH_MESSAGE;
                        end
                    end
                end
                PH_MESSAGE: begin
                    if (r_count == '0) begin
                        n_type = i_rx_byte;
                    end else if (r_count <= PAYLOAD_HEAD) begin
                        n_pay_shift = {r_pay_shift[55:0], i_rx_byte};
                    end else begin
                        n_pay_tail = {r_pay_tail[23:0], i_rx_byte};
                    end
                    n_count = count_inc;
                    if (count_inc >= r_msg_len) begin
                        n_count        = '0;
                        n_len_shift    = '0;
                        n_phase        = PH_LENGTH;
                        o_push         = 1'b1;
                        o_cmd.msg_type = n_type;
                        if (r_msg_len == REQ_MSG_LEN &&
                            (n_type == TYPE_REQUEST || n_type == TYPE_CANCEL)) begin
                            o_cmd.ev     = (n_type == TYPE_REQUEST) ? EV_REQUEST
                                                                    : EV_CANCEL;
                            o_cmd.piece  = n_pay_shift[63:32];
                            o_cmd.offset = n_pay_shift[31:0];
                            o_cmd.length = n_pay_tail;
                        end else begin
                            o_cmd.ev = EV_IGNORED;
                        end
                    end
                end
                PH_HALTED: begin
                    // bytes are dropped until reset
                end
                default: begin
                    n_phase = PH_HALTED;
                end
            endcase
        end
    end

endmodule

### rtl/pwrp_queue.sv
// ----------------------------------------------------------------------------
// pwrp_queue
// Small register FIFO of commands between the parser and the output stage.
// ----------------------------------------------------------------------------
module pwrp_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  pwrp_pkg::t_cmd  i_cmd,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output pwrp_pkg::t_cmd  o_cmd
);
    import pwrp_pkg::*;

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QPTR_W:0]   r_fill;
    logic              do_push, do_pop;

    assign o_full  = (r_fill == (QPTR_W+1)'(QDEPTH));
    assign o_empty = (r_fill == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd_ptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (do_pop && !do_push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

### rtl/pwrp_back.sv
// ----------------------------------------------------------------------------
// pwrp_back
// Output stage: holds the info hash, expands a hash command into 20 items
// and presents each result in an output register.
// ----------------------------------------------------------------------------
module pwrp_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  pwrp_pkg::t_hash_wr           i_hash_wr,
    // command queue
    input  logic                         i_q_empty,
    input  pwrp_pkg::t_cmd               i_cmd,
    output logic                         o_pop,
    // result output
    output logic                         o_valid,
    input  logic                         i_ready,
    output pwrp_pkg::t_event             o_event,
    output logic [pwrp_pkg::HIDX_W-1:0]  o_hash_index,
    output logic [7:0]                   o_hash_byte,
    output logic [7:0]                   o_msg_type,
    output logic [31:0]                  o_piece,
    output logic [31:0]                  o_offset,
    output logic [31:0]                  o_length,
    output logic                         o_last
);
    import pwrp_pkg::*;

    logic [7:0]        r_hash [20];
    logic              r_valid, n_valid;
    logic              r_burst, n_burst;
    logic [HIDX_W-1:0] r_hidx, n_hidx;
    t_event            r_event, n_event;
    logic [HIDX_W-1:0] r_oidx, n_oidx;
    logic [7:0]        r_obyte, n_obyte;
    logic [7:0]        r_mtype, n_mtype;
    logic [31:0]       r_piece, n_piece;
    logic [31:0]       r_offset, n_offset;
    logic [31:0]       r_length, n_length;
    logic              r_last, n_last;
    logic              load;

    assign load = !r_valid || i_ready;

    // info hash store
    always_ff @(posedge i_clk) begin
        if (i_hash_wr.en) begin
            r_hash[i_hash_wr.idx] <= i_hash_wr.data;
        end
    end

    // select the next output item
    always_comb begin
        n_valid  = r_valid;
        n_burst  = r_burst;
        n_hidx   = r_hidx;
        n_event  = r_event;
        n_oidx   = r_oidx;
        n_obyte  = r_obyte;
        n_mtype  = r_mtype;
        n_piece  = r_piece;
        n_offset = r_offset;
        n_length = r_length;
        n_last   = r_last;
        o_pop    = 1'b0;
        if (load) begin
            if (r_burst) begin
                // continue the hash burst
                n_valid  = 1'b1;
                n_event  = EV_HASH;
                n_oidx   = r_hidx;
                n_obyte  = r_hash[r_hidx];
                n_mtype  = '0;
                n_piece  = '0;
                n_offset = '0;
                n_length = '0;
                n_last   = (r_hidx == HASH_LAST);
                n_burst  = (r_hidx != HASH_LAST);
                n_hidx   = r_hidx + 1'b1;
            end else if (!i_q_empty) begin
                o_pop    = 1'b1;
                n_valid  = 1'b1;
                n_event  = i_cmd.ev;
                n_mtype  = i_cmd.msg_type;
                n_piece  = i_cmd.piece;
                n_offset = i_cmd.offset;
                n_length = i_cmd.length;
                n_oidx   = '0;
                if (i_cmd.ev == EV_HASH) begin
                    // first hash byte now, the rest follow from the burst
                    n_obyte = r_hash[0];
                    n_last  = 1'b0;
                    n_burst = 1'b1;
                    n_hidx  = HIDX_W'(1);
                end else begin
                    n_obyte = '0;
                    n_last  = 1'b1;
                end
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_burst <= 1'b0;
            r_hidx  <= '0;
        end else begin
            r_valid <= n_valid;
            r_burst <= n_burst;
            r_hidx  <= n_hidx;
        end
    end

    // output payload registers
    always_ff @(posedge i_clk) begin
        r_event  <= n_event;
        r_oidx   <= n_oidx;
        r_obyte  <= n_obyte;
        r_mtype  <= n_mtype;
        r_piece  <= n_piece;
        r_offset <= n_offset;
        r_length <= n_length;
        r_last   <= n_last;
    end

    assign o_valid      = r_valid;
    assign o_event      = r_event;
    assign o_hash_index = r_oidx;
    assign o_hash_byte  = r_obyte;
    assign o_msg_type   = r_mtype;
    assign o_piece      = r_piece;
    assign o_offset     = r_offset;
    assign o_length     = r_length;
    assign o_last       = r_last;

endmodule

### rtl/peer_wire_receive_parser.sv
// ----------------------------------------------------------------------------
// peer_wire_receive_parser
// Byte-serial parser for the peer-wire handshake and message framing.
// ----------------------------------------------------------------------------
// Usage:
//   Received bytes enter on the s_axis channel, one item per byte in tdata.
//   One byte is taken every cycle while the command queue has room.
//   Results leave on the m_axis channel: the event code in tuser, the other
//   fields in tdata, and tlast on the final result caused by one byte.
//   A good handshake yields 20 hash items, one per cycle while m_axis tready
//   is high; every other event yields one item. A result passes from the
//   parser into the command queue, then into the output register.
//   The parser and the output stage are joined by a four-entry command
//   queue: a stalled receiver first fills the output register, then the
//   queue, and only then is s_axis tready dropped. The 20 peer id bytes
//   after the handshake give the hash burst time to drain.
//   The APB port holds max_message_length at address 0; write it idle only.
//   Reset (synchronous, active low) returns to the handshake phase, clears
//   the queue and the output, and sets the length limit to 262144.
//   After bad_protocol or too_long all bytes are taken and dropped.
// ----------------------------------------------------------------------------
module peer_wire_receive_parser (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // byte input
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [7:0]                  i_s_axis_tdata,   // [7:0] rx_byte
    // result output
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    // [4:0] hash_index, [12:5] hash_byte, [20:13] msg_type, [52:21] piece,
    // [84:53] block_offset, [116:85] block_length, [119:117] zero
    output logic [119:0]                o_m_axis_tdata,
    output logic [2:0]                  o_m_axis_tuser,   // [2:0] event_res
    output logic                        o_m_axis_tlast,   // last
    // configuration
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic [pwrp_pkg::ADDR_W-1:0] i_paddr,
    input  logic [31:0]                 i_pwdata,
    output logic [31:0]                 o_prdata,
    output logic                        o_pready
);
    import pwrp_pkg::*;

    t_cmd              front_cmd, q_cmd;
    t_hash_wr          hash_wr;
    t_event            out_event;
    logic              push, pop, q_full, q_empty, cfg_we;
    logic [CNT_W-1:0]  max_len;
    logic [HIDX_W-1:0] out_hidx;
    logic [7:0]        out_hbyte, out_mtype;
    logic [31:0]       out_piece, out_offset, out_length;

    // APB access
    assign o_pready = 1'b1;
    assign cfg_we   = i_psel && i_penable && i_pwrite;
    assign o_prdata = (i_paddr == ADDR_MAX_LEN) ? {7'd0, max_len} : 32'd0;

    pwrp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_rx_byte   (i_s_axis_tdata),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (i_paddr),
        .i_cfg_wdata (i_pwdata),
        .o_max_len   (max_len),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_cmd       (front_cmd),
        .o_hash_wr   (hash_wr)
    );

    pwrp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_cmd   (q_cmd)
    );

    pwrp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_hash_wr    (hash_wr),
        .i_q_empty    (q_empty),
        .i_cmd        (q_cmd),
        .o_pop        (pop),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_event      (out_event),
        .o_hash_index (out_hidx),
        .o_hash_byte  (out_hbyte),
        .o_msg_type   (out_mtype),
        .o_piece      (out_piece),
        .o_offset     (out_offset),
        .o_length     (out_length),
        .o_last       (o_m_axis_tlast)
    );

    // output packing
    assign o_m_axis_tuser = out_event;
    assign o_m_axis_tdata = {3'd0, out_length, out_offset, out_piece,
                             out_mtype, out_hbyte, out_hidx};

endmodule

### tb/peer_wire_receive_parser_tb.sv
// ----------------------------------------------------------------------------
// peer_wire_receive_parser_tb
// Self-checking bench for the peer-wire receive parser. A queue of stream
// bytes (handshake, peer id, then framed messages) feeds a clocked driver.
// Each accepted byte runs through a bit-accurate predictor of the parser,
// and a clocked monitor compares every result item field by field with the
// oldest predicted one. Both sides idle at random, the receiver holds off
// once for a long stretch, and the length limit is rewritten between phases
// (zero, exact request size, one, reset value, 2^24).
// ----------------------------------------------------------------------------
module peer_wire_receive_parser_tb;

    import pwrp_pkg::*;

    localparam int unsigned   HANDSHAKE_BYTES = 48;
    localparam int unsigned   PROTO_BYTES     = 20;
    localparam int unsigned   HASH_FIRST      = 28;
    localparam int unsigned   HASH_BYTES      = 20;
    localparam int unsigned   PEER_ID_BYTES   = 20;
    localparam int unsigned   LEN_BYTES       = 4;
    localparam int unsigned   REQ_BYTES       = 13;
    localparam logic [7:0]    OP_REQUEST      = 8'd6;
    localparam logic [7:0]    OP_CANCEL       = 8'd8;
    localparam logic [24:0]   LIMIT_RESET     = 25'd262144;
    localparam logic [24:0]   LIMIT_TOP       = 25'd16777216;
    localparam logic [ADDR_W-1:0] ADDR_NO_REG = 3'd4;
    localparam int unsigned   SETTLE_CYCLES   = 8;
    localparam int unsigned   HOLD_AFTER      = 30;
    localparam int unsigned   HOLD_CYCLES     = 200;
    localparam int unsigned   WATCHDOG_LIMIT  = 4000;

    typedef struct {
        t_event      ev;
        logic [4:0]  hidx;
        logic [7:0]  hbyte;
        logic [7:0]  mtype;
        logic [31:0] piece;
        logic [31:0] offset;
        logic [31:0] blen;
        logic        last;
    } t_result;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_tvalid = 1'b0;
    logic [7:0]         s_tdata = 8'd0;
    logic               o_s_tready;
    logic               o_m_tvalid;
    logic               m_tready = 1'b0;
    logic [119:0]       o_m_tdata;
    logic [2:0]         o_m_tuser;
    logic               o_m_tlast;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [ADDR_W-1:0]  paddr = '0;
    logic [31:0]        pwdata = 32'd0;
    logic [31:0]        o_prdata;
    logic               o_pready;

    // stimulus and expectations
    logic [7:0]   rx_bytes[$];
    t_result      pending_results[$];
    int unsigned  errors = 0;
    int unsigned  bytes_sent = 0;
    int unsigned  results_checked = 0;
    int unsigned  ev_seen[8];
    int unsigned  quiet_cycles = 0;

    // idling control, each side owns its own counters
    int unsigned  tx_gap = 0;
    int unsigned  tx_span = 0;
    bit           tx_steady = 1'b0;
    int unsigned  rx_wait = 0;
    int unsigned  rx_span = 0;
    bit           rx_steady = 1'b0;
    int unsigned  hold_left = 0;
    bit           hold_done = 1'b0;

    // parser shadow state
    string        proto_txt = "BitTorrent protocol";
    logic [24:0]  lim_cfg = LIMIT_RESET;
    t_phase       ph = PH_HANDSHAKE;
    logic [24:0]  cnt = '0;
    logic         mism = 1'b0;
    logic [7:0]   hash_mem[HASH_BYTES];
    logic [31:0]  len_sh = '0;
    logic [24:0]  msg_len = '0;
    logic [7:0]   type_b = '0;
    logic [63:0]  pay_sh = '0;
    logic [31:0]  pay_tail = '0;

    peer_wire_receive_parser dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (o_m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_tdata),
        .o_m_axis_tuser  (o_m_tuser),
        .o_m_axis_tlast  (o_m_tlast),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .o_prdata        (o_prdata),
        .o_pready        (o_pready)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic void push_result(t_event ev, logic [4:0] hidx, logic [7:0] hbyte,
                                        logic [7:0] mtype, logic [31:0] piece,
                                        logic [31:0] offset, logic [31:0] blen,
                                        logic last);
        t_result r;
        r.ev     = ev;
        r.hidx   = hidx;
        r.hbyte  = hbyte;
        r.mtype  = mtype;
        r.piece  = piece;
        r.offset = offset;
        r.blen   = blen;
        r.last   = last;
        pending_results.insert(pending_results.size(), r);
    endfunction

    function automatic void parse_rx_byte(logic [7:0] b);
        int unsigned i;
        logic [7:0]  proto_exp;
        case (ph)
            PH_HANDSHAKE: begin
                if (cnt < PROTO_BYTES) begin
                    proto_exp = (cnt == 0) ? 8'd19 : proto_txt[cnt - 1];
                    if (b != proto_exp) mism = 1'b1;
                end else if (cnt >= HASH_FIRST) begin
                    hash_mem[cnt - HASH_FIRST] = b;
                end
                cnt = cnt + 1'b1;
                if (cnt == HANDSHAKE_BYTES) begin
                    cnt = '0;
                    if (mism) begin
                        ph = PH_HALTED;
                        push_result(EV_BADPROTO, 0, 0, 0, 0, 0, 0, 1'b1);
                    end else begin
                        ph = PH_PEERID;
                        for (i = 0; i < HASH_BYTES; i++)
                            push_result(EV_HASH, 5'(i), hash_mem[i], 0, 0, 0, 0,
                                        i == HASH_BYTES - 1);
                    end
                end
            end
            PH_PEERID: begin
                cnt = cnt + 1'b1;
                if (cnt >= PEER_ID_BYTES) begin
                    cnt    = '0;
                    len_sh = '0;
                    ph     = PH_LENGTH;
                end
            end
            PH_LENGTH: begin
                len_sh = {len_sh[23:0], b};
                cnt    = cnt + 1'b1;
                if (cnt == LEN_BYTES) begin
                    cnt = '0;
                    if (len_sh == 0) begin
                        push_result(EV_KEEPALIVE, 0, 0, 0, 0, 0, 0, 1'b1);
                    end else if (len_sh > {7'd0, lim_cfg}) begin
                        ph = PH_HALTED;
                        push_result(EV_TOOLONG, 0, 0, 0, 0, 0, 0, 1'b1);
                    end else begin
                        msg_len  = len_sh[24:0];
                        type_b   = '0;
                        pay_sh   = '0;
                        pay_tail = '0;
                        ph       = PH_MESSAGE;
                    end
                end
            end
            PH_MESSAGE: begin
                if (cnt == 0)
                    type_b = b;
                else if (cnt <= 8)
                    pay_sh = {pay_sh[55:0], b};
                else
                    pay_tail = {pay_tail[23:0], b};
                cnt = cnt + 1'b1;
                if (cnt >= msg_len) begin
                    cnt    = '0;
                    len_sh = '0;
                    ph     = PH_LENGTH;
                    if (msg_len == REQ_BYTES && (type_b == OP_REQUEST || type_b == OP_CANCEL))
                        push_result(type_b == OP_REQUEST ? EV_REQUEST : EV_CANCEL, 0, 0,
                                    type_b, pay_sh[63:32], pay_sh[31:0], pay_tail, 1'b1);
                    else
                        push_result(EV_IGNORED, 0, 0, type_b, 0, 0, 0, 1'b1);
                end
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------------
    // mostly short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 92) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    // append one byte to the stream
    function automatic void add_byte(input logic [7:0] b);
        rx_bytes.insert(rx_bytes.size(), b);
    endfunction

    // length prefix, type byte, first 12 payload bytes from head, random tail
    task automatic queue_msg(input logic [31:0] len, input logic [7:0] op,
                             input logic [95:0] head);
        int unsigned k;
        for (k = 0; k < LEN_BYTES; k++)
            add_byte(len[31 - 8*k -: 8]);
        if (len != 0)
            add_byte(op);
        for (k = 1; k < len; k++)
            add_byte(k <= 12 ? head[103 - 8*k -: 8] : 8'($urandom));
    endtask

    task automatic queue_random_msg(input logic [24:0] lim);
        int unsigned pick;
        logic [31:0] len;
        logic [7:0]  op;
        pick = $urandom_range(0, 99);
        op   = $urandom_range(0, 1) ? OP_REQUEST : OP_CANCEL;
        if (pick < 12) begin
            len = 0;
        end else if (pick < 45) begin
            len = REQ_BYTES;
        end else if (pick < 60) begin
            len = $urandom_range(1, 20);
            if (len == REQ_BYTES) len = REQ_BYTES + 1;
        end else if (pick < 90) begin
            len = $urandom_range(1, 16);
            op  = 8'($urandom);
        end else begin
            len = $urandom_range(20, 64);
            op  = 8'($urandom);
        end
        if (len > lim) len = lim;
        queue_msg(len, op, {$urandom, $urandom, $urandom});
    endtask

    // wait until all bytes are taken and all results seen, then let the design settle
    task automatic wait_drained();
        do @(negedge clk);
        while (rx_bytes.size() != 0 || s_tvalid || pending_results.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [24:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= {7'd0, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_MAX_LEN) lim_cfg = val;
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Byte driver
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : byte_driver
        logic fire;
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            fire = s_tvalid && o_s_tready;
            if (fire) begin
                parse_rx_byte(s_tdata);
                bytes_sent++;
                tx_gap = tx_steady ? 0 : pick_gap();
            end
            // occasional windows with no gaps at all
            if (tx_span == 0) begin
                tx_span   = $urandom_range(100, 300);
                tx_steady = ($urandom_range(0, 3) == 0);
            end else begin
                tx_span--;
            end
            if (!s_tvalid || fire) begin
                if (tx_gap == 0 && rx_bytes.size() != 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= rx_bytes[0];
                    rx_bytes.delete(0);
                end else begin
                    s_tvalid <= 1'b0;
                    if (tx_gap != 0) tx_gap--;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : result_monitor
        t_result want;
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && m_tready) begin
                ev_seen[o_m_tuser]++;
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected item: expected none, actual event %0d tdata %0h",
                             $time, o_m_tuser, o_m_tdata);
                    errors++;
                end else begin
                    want = pending_results[0];
                    pending_results.delete(0);
                    check_field("event_res",    32'(want.ev),    32'(o_m_tuser));
                    check_field("hash_index",   32'(want.hidx),  32'(o_m_tdata[4:0]));
                    check_field("hash_byte",    32'(want.hbyte), 32'(o_m_tdata[12:5]));
                    check_field("msg_type",     32'(want.mtype), 32'(o_m_tdata[20:13]));
                    check_field("piece",        want.piece,      o_m_tdata[52:21]);
                    check_field("block_offset", want.offset,     o_m_tdata[84:53]);
                    check_field("block_length", want.blen,       o_m_tdata[116:85]);
                    check_field("last",         32'(want.last),  32'(o_m_tlast));
                end
                results_checked++;
            end
            if (rx_span == 0) begin
                rx_span   = $urandom_range(100, 300);
                rx_steady = ($urandom_range(0, 3) == 0);
            end else begin
                rx_span--;
            end
            // one long hold-off so the command queue fills and input stalls
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (!hold_done && results_checked >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                m_tready <= 1'b0;
            end else if (rx_wait != 0) begin
                rx_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                rx_wait = rx_steady ? 0 : pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: no item moving on either side for too long
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if ((s_tvalid && o_s_tready) || (o_m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d items still expected",
                     $time, pending_results.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int unsigned k;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // handshake: protocol string, reserved, hash with extreme end bytes
        add_byte(8'd19);
        for (k = 0; k < PROTO_BYTES - 1; k++)
            add_byte(proto_txt[k]);
        for (k = 0; k < 8; k++)
            add_byte(k[0] ? 8'hFF : 8'h00);
        for (k = 0; k < HASH_BYTES; k++)
            add_byte(k == 0 ? 8'h00 : k == HASH_BYTES - 1 ? 8'hFF : 8'($urandom));
        for (k = 0; k < PEER_ID_BYTES; k++)
            add_byte(8'($urandom));

        // directed messages under the reset limit
        queue_msg(0, 8'd0, '0);                              // keep-alive
        queue_msg(REQ_BYTES, OP_REQUEST, {96{1'b1}});        // request, all ones
        queue_msg(REQ_BYTES, OP_CANCEL, '0);                 // cancel, all zero
        queue_msg(REQ_BYTES, OP_REQUEST, 96'h0102_0304_A5A6_A7A8_8000_0001);
        queue_msg(REQ_BYTES - 1, OP_REQUEST, {$urandom, $urandom, $urandom});
        queue_msg(REQ_BYTES + 1, OP_CANCEL, {$urandom, $urandom, $urandom});
        queue_msg(1, 8'h00, '0);                             // type byte only
        queue_msg(5, 8'hFF, {$urandom, $urandom, $urandom});
        queue_msg(24, 8'h07, {$urandom, $urandom, $urandom}); // long, tail bytes
        wait_drained();

        // zero limit: only keep-alives are legal; long hold-off falls here
        apb_write(ADDR_MAX_LEN, 25'd0);
        repeat (16) queue_msg(0, 8'd0, '0);
        wait_drained();

        // limit of 2^24, plus a write to an unmapped address
        apb_write(ADDR_MAX_LEN, LIMIT_TOP);
        apb_write(ADDR_NO_REG, 25'd0);
        repeat (3) queue_random_msg(lim_cfg);
        wait_drained();

        // limit equal to the request size
        apb_write(ADDR_MAX_LEN, 25'(REQ_BYTES));
        repeat (3) queue_random_msg(lim_cfg);
        wait_drained();

        // limit of one: type byte only
        apb_write(ADDR_MAX_LEN, 25'd1);
        repeat (4) queue_random_msg(lim_cfg);
        wait_drained();

        apb_write(ADDR_MAX_LEN, LIMIT_RESET);
        repeat (3) queue_random_msg(lim_cfg);
        wait_drained();

        // oversize length whose low 25 bits are zero, then bytes while halted
        apb_write(ADDR_MAX_LEN, LIMIT_TOP);
        repeat (2) queue_random_msg(lim_cfg);
        add_byte(8'(2 * $urandom_range(1, 127)));
        repeat (3) add_byte(8'h00);
        repeat (20) add_byte(8'($urandom));
        wait_drained();

        $display("Sent %0d bytes, checked %0d result items", bytes_sent, results_checked);
        $display("hash %0d, keep-alive %0d, request %0d, cancel %0d, ignored %0d, too-long %0d",
                 ev_seen[EV_HASH], ev_seen[EV_KEEPALIVE], ev_seen[EV_REQUEST],
                 ev_seen[EV_CANCEL], ev_seen[EV_IGNORED], ev_seen[EV_TOOLONG]);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
